// ----- rtl/mme_pkg.sv -----
package mme_pkg;

    // Width of the base, the modulus and the result.
    localparam int VAL_W = 31;

    // Default exponent width handed to the top level.
    localparam int EXP_W_DEF = 63;

    // One multiplier bit is consumed per cycle by the modular multiplier.
    localparam int MUL_STEPS = VAL_W;
    localparam int MUL_CNT_W = $clog2(MUL_STEPS);

    localparam logic [VAL_W-1:0] MOD_RESET = VAL_W'(1000000007);
    localparam logic [VAL_W-1:0] VAL_ONE   = VAL_W'(1);
    localparam logic [VAL_W-1:0] VAL_TWO   = VAL_W'(2);

    // Request into the shared modular multiplier.
    typedef struct packed {
        logic             start;
        logic [VAL_W-1:0] a;
        logic [VAL_W-1:0] b;
    } mme_mul_req_t;

    // Answer from the shared modular multiplier.
    typedef struct packed {
        logic             done;
        logic [VAL_W-1:0] result;
    } mme_mul_resp_t;

    // Sequencer states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_REDUCE,
        S_STEP,
        S_MUL,
        S_SQR,
        S_DONE
    } mme_state_t;

endpackage

// ----- rtl/mme_mulmod.sv -----
module mme_mulmod
    import mme_pkg::*;
(
    input  logic          aclk,
    input  logic          aresetn,
    input  logic [VAL_W-1:0] modulus,
    input  mme_mul_req_t  req,
    output mme_mul_resp_t resp
);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [VAL_W-1:0]     a_reg, a_next;
    logic [VAL_W-1:0]     b_reg, b_next;
    logic [VAL_W-1:0]     r_reg, r_next;
    logic [MUL_CNT_W-1:0] cnt_reg, cnt_next;

    logic [VAL_W+1:0]     sum;
    logic [VAL_W+1:0]     m1;
    logic [VAL_W+1:0]     m2;
    logic [VAL_W+1:0]     d1;
    logic [VAL_W+1:0]     d2;
    logic [VAL_W-1:0]     r_step;

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    // Operand and remainder registers.
    always_ff @(posedge aclk) begin
        a_reg   <= a_next;
        b_reg   <= b_next;
        r_reg   <= r_next;
        cnt_reg <= cnt_next;
    end

    // One interleaved step: r = 2r + a_bit * b, then bring it below the
    // modulus. With r and b below m the sum stays below 3m.
    always_comb begin
        sum = {1'b0, r_reg, 1'b0} + (a_reg[VAL_W-1] ? {2'b00, b_reg} : '0);
        m1  = {2'b00, modulus};
        m2  = {1'b0, modulus, 1'b0};
        d1  = sum - m1;
        d2  = sum - m2;
        if (sum >= m2) begin
            r_step = d2[VAL_W-1:0];
        end else if (sum >= m1) begin
            r_step = d1[VAL_W-1:0];
        end else begin
            r_step = sum[VAL_W-1:0];
        end
    end

    // Step control: load on start, then walk the multiplier from its top bit.
    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        a_next    = a_reg;
        b_next    = b_reg;
        r_next    = r_reg;
        cnt_next  = cnt_reg;
        if (req.start) begin
            busy_next = 1'b1;
            a_next    = req.a;
            b_next    = req.b;
            r_next    = '0;
            cnt_next  = '0;
        end else if (busy_reg) begin
            a_next   = {a_reg[VAL_W-2:0], 1'b0};
            r_next   = r_step;
            cnt_next = cnt_reg + MUL_CNT_W'(1);
            if (cnt_reg == MUL_CNT_W'(MUL_STEPS - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    assign resp.done   = done_reg;
    assign resp.result = r_reg;

    // A new product is never requested while one is in progress.
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        req.start |-> !busy_reg)
        else $error("multiplier started while busy");

    // The last step is followed by a done pulse.
    a_done_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (busy_reg && !req.start && cnt_reg == MUL_CNT_W'(MUL_STEPS - 1)) |=> done_reg)
        else $error("missing done after last step");

    // Done and busy never overlap.
    a_done_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> !busy_reg)
        else $error("done while busy");

endmodule

// ----- rtl/mme_seq.sv -----
module mme_seq
    import mme_pkg::*;
#(
    parameter int EXP_WIDTH = EXP_W_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [VAL_W-1:0]     in_base,
    input  logic [EXP_WIDTH-1:0] in_exp,
    input  logic [VAL_W-1:0]     modulus,
    output mme_mul_req_t         mul_req,
    input  mme_mul_resp_t        mul_resp,
    output logic                 res_valid,
    input  logic                 res_take,
    output logic [VAL_W-1:0]     res_value
);

    mme_state_t           state_reg, state_next;
    logic [EXP_WIDTH-1:0] exp_reg, exp_next;
    logic [VAL_W-1:0]     acc_reg, acc_next;
    logic [VAL_W-1:0]     run_reg, run_next;
    logic                 exp_last;

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Exponent, accumulator and running base.
    always_ff @(posedge aclk) begin
        exp_reg <= exp_next;
        acc_reg <= acc_next;
        run_reg <= run_next;
    end

    // True when the current exponent bit is the highest one left.
    assign exp_last = ((exp_reg >> 1) == '0);

    // Square-and-multiply sequencing, exponent bits taken from the bottom.
    always_comb begin
        state_next  = state_reg;
        exp_next    = exp_reg;
        acc_next    = acc_reg;
        run_next    = run_reg;
        mul_req     = '0;
        mul_req.a   = acc_reg;
        mul_req.b   = run_reg;
        in_ready    = 1'b0;
        res_valid   = 1'b0;
        case (state_reg)
            S_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    exp_next = in_exp;
                    if (in_exp == '0) begin
                        acc_next   = VAL_ONE;
                        state_next = S_DONE;
                    end else if (modulus < VAL_TWO) begin
                        acc_next   = '0;
                        state_next = S_DONE;
                    end else begin
                        // Reduce the base first: base * 1 mod m.
                        acc_next      = VAL_ONE;
                        mul_req.start = 1'b1;
                        mul_req.a     = in_base;
                        mul_req.b     = VAL_ONE;
                        state_next    = S_REDUCE;
                    end
                end
            end
            S_REDUCE: begin
                if (mul_resp.done) begin
                    run_next   = mul_resp.result;
                    state_next = S_STEP;
                end
            end
            S_STEP: begin
                mul_req.start = 1'b1;
                if (exp_reg[0]) begin
                    state_next = S_MUL;
                end else begin
                    mul_req.a  = run_reg;
                    state_next = S_SQR;
                end
            end
            S_MUL: begin
                if (mul_resp.done) begin
                    acc_next = mul_resp.result;
                    if (exp_last) begin
                        state_next = S_DONE;
                    end else begin
                        mul_req.start = 1'b1;
                        mul_req.a     = run_reg;
                        state_next    = S_SQR;
                    end
                end
            end
            S_SQR: begin
                if (mul_resp.done) begin
                    run_next   = mul_resp.result;
                    exp_next   = exp_reg >> 1;
                    state_next = S_STEP;
                end
            end
            S_DONE: begin
                res_valid = 1'b1;
                if (res_take) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign res_value = acc_reg;

    // A finished product only arrives in a state that waits for one.
    a_resp_expected: assert property (@(posedge aclk) disable iff (!aresetn)
        mul_resp.done |->
            (state_reg == S_REDUCE || state_reg == S_MUL || state_reg == S_SQR))
        else $error("unexpected multiplier result");

    // The step state always hands work to the multiplier.
    a_step_issues: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_STEP) |=> (state_reg == S_MUL || state_reg == S_SQR))
        else $error("step state did not issue a product");

endmodule

// ----- rtl/modular_exponentiation_core.sv -----
// Modular exponentiation core: returns base_value to the power exponent,
// reduced modulo the modulus register (reset value 1000000007), using
// right-to-left binary square-and-multiply. An exponent of zero gives 1,
// and a modulus below 2 gives 0 for any nonzero exponent. Items are taken
// one at a time: s_axis_tready is high only while the core is idle. All
// arithmetic runs through one bit-serial modular multiplier, and for each
// exponent bit a step state issues the next product. The result sits
// in an output register, so the next word can be accepted while it
// waits. Write the modulus only while the core is idle.
module modular_exponentiation_core
    import mme_pkg::*;
#(
    parameter int EXP_WIDTH = EXP_W_DEF,
    localparam int S_DATA_W = ((VAL_W + EXP_WIDTH + 7) / 8) * 8,
    localparam int M_DATA_W = ((VAL_W + 7) / 8) * 8
) (
    input  logic                aclk,
    input  logic                aresetn,
    // Modulus register write.
    input  logic                cfg_wen,
    input  logic [VAL_W-1:0]    cfg_wdata,
    // Input words.
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [S_DATA_W-1:0] s_axis_tdata,  // base_value, exponent
    // Result words.
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [M_DATA_W-1:0] m_axis_tdata   // power_result
);

    logic [VAL_W-1:0] modulus_reg;
    logic             out_valid_reg, out_valid_next;
    logic [VAL_W-1:0] out_data_reg;
    logic             res_valid;
    logic             res_take;
    logic [VAL_W-1:0] res_value;
    mme_mul_req_t     mul_req;
    mme_mul_resp_t    mul_resp;

    // Modulus register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            modulus_reg <= MOD_RESET;
        end else if (cfg_wen) begin
            modulus_reg <= cfg_wdata;
        end
    end

    // Output register: loads when empty or being drained.
    assign res_take = res_valid && (!out_valid_reg || m_axis_tready);

    always_comb begin
        out_valid_next = out_valid_reg;
        if (res_take) begin
            out_valid_next = 1'b1;
        end else if (m_axis_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_take) begin
            out_data_reg <= res_value;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(M_DATA_W - VAL_W){1'b0}}, out_data_reg};

    // Sequencer.
    mme_seq #(
        .EXP_WIDTH (EXP_WIDTH)
    ) u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_base   (s_axis_tdata[VAL_W-1:0]),
        .in_exp    (s_axis_tdata[VAL_W +: EXP_WIDTH]),
        .modulus   (modulus_reg),
        .mul_req   (mul_req),
        .mul_resp  (mul_resp),
        .res_valid (res_valid),
        .res_take  (res_take),
        .res_value (res_value)
    );

    // Shared modular multiplier.
    mme_mulmod u_mulmod (
        .aclk    (aclk),
        .aresetn (aresetn),
        .modulus (modulus_reg),
        .req     (mul_req),
        .resp    (mul_resp)
    );

endmodule

// ----- sim/modular_exponentiation_core_test.sv -----
`timescale 1ns / 1ps

module modular_exponentiation_core_test;
    import mme_pkg::*;

    localparam int EXP_W      = EXP_W_DEF;
    localparam int S_W        = ((VAL_W + EXP_W + 7) / 8) * 8;
    localparam int M_W        = ((VAL_W + 7) / 8) * 8;
    localparam int CYCLE_CAP  = 8000000;
    localparam int SETTLE     = 64;

    localparam logic [VAL_W-1:0] BASE_MAX = '1;
    localparam logic [EXP_W-1:0] EXP_ONES = '1;

    // One accepted input word and the power it should produce.
    typedef struct {
        logic [VAL_W-1:0] base_value;
        logic [EXP_W-1:0] exponent;
        logic [VAL_W-1:0] power;
    } power_job_t;

    logic aclk = 1'b0;
    logic aresetn;
    logic cfg_wen;
    logic [VAL_W-1:0] cfg_wdata;
    logic s_axis_tvalid;
    logic s_axis_tready;
    logic [S_W-1:0] s_axis_tdata;  // base_value, exponent
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [M_W-1:0] m_axis_tdata;  // power_result

    power_job_t pending_powers[$];
    logic [VAL_W-1:0] modulus_copy;
    int mismatch_count = 0;
    int cycle_count = 0;
    int burst_left = 0;
    bit sender_bursty = 1'b1;
    bit receiver_stalls = 1'b1;
    logic [31:0] ready_pattern = '1;
    int ready_slot = 0;

    modular_exponentiation_core DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wen       (cfg_wen),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #4 aclk = ~aclk;

    // Right-to-left square-and-multiply with 64-bit products; the base
    // enters unreduced, which the 62-bit product range allows.
    function automatic logic [VAL_W-1:0] expected_power(input logic [VAL_W-1:0] b,
                                                        input logic [EXP_W-1:0] e,
                                                        input logic [VAL_W-1:0] m);
        logic [63:0] acc;
        logic [63:0] run;
        logic [63:0] m64;
        logic [EXP_W-1:0] rest;
        if (e == '0) begin
            return VAL_ONE;
        end
        if (m < VAL_TWO) begin
            return '0;
        end
        acc = 64'd1;
        run = 64'(b);
        m64 = 64'(m);
        rest = e;
        while (rest != '0) begin
            if (rest[0]) begin
                acc = (acc * run) % m64;
            end
            rest = rest >> 1;
            if (rest != '0) begin
                run = (run * run) % m64;
            end
        end
        return acc[VAL_W-1:0];
    endfunction

    // Bases lean toward the edges and toward values at and just above the modulus.
    function automatic logic [VAL_W-1:0] random_base();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return VAL_ONE;
            2: return BASE_MAX;
            3: return VAL_W'($urandom_range(2, 300));
            4: return modulus_copy + VAL_W'($urandom_range(0, 5));
            default: return VAL_W'($urandom);
        endcase
    endfunction

    // Mostly short exponents keep the run short; a share is full width.
    function automatic logic [EXP_W-1:0] random_exponent();
        logic [63:0] raw;
        int width;
        raw = {$urandom, $urandom};
        case ($urandom_range(0, 19))
            0: return '0;
            1, 2, 3: return raw[EXP_W-1:0];
            4: return EXP_ONES >> $urandom_range(0, 8);
            default: begin
                width = $urandom_range(1, 24);
                return EXP_W'(raw & ((64'd1 << width) - 64'd1));
            end
        endcase
    endfunction

    task automatic report_mismatch(input string what);
        $display("MISMATCH at cycle %0d: %s", cycle_count, what);
        mismatch_count++;
    endtask

    // Present one word, holding it until the core takes it.
    task automatic send_word(input logic [VAL_W-1:0] b, input logic [EXP_W-1:0] e);
        power_job_t job;
        if (burst_left == 0) begin
            if (sender_bursty) begin
                s_axis_tvalid = 1'b0;
                repeat ($urandom_range(1, 24)) @(negedge aclk);
            end
            burst_left = $urandom_range(1, 10);
        end
        burst_left--;
        s_axis_tdata = '0;
        s_axis_tdata[VAL_W-1:0] = b;
        s_axis_tdata[VAL_W +: EXP_W] = e;
        s_axis_tvalid = 1'b1;
        do @(posedge aclk); while (!s_axis_tready);
        job.base_value = b;
        job.exponent = e;
        job.power = expected_power(b, e, modulus_copy);
        pending_powers.push_back(job);
        @(negedge aclk);
    endtask

    // Stop sending and wait until every expected word has come back.
    task automatic drain();
        s_axis_tvalid = 1'b0;
        while (pending_powers.size() != 0) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic set_modulus(input logic [VAL_W-1:0] m);
        drain();
        cfg_wdata = m;
        cfg_wen = 1'b1;
        @(negedge aclk);
        cfg_wen = 1'b0;
        modulus_copy = m;
    endtask

    task automatic test_zero_exponent();
        send_word('0, '0);
        send_word(BASE_MAX, '0);
    endtask

    task automatic test_field_extremes();
        send_word('0, EXP_W'(1));
        send_word(BASE_MAX, EXP_W'(1));
        send_word(BASE_MAX, EXP_W'(2));
        send_word(BASE_MAX, EXP_ONES);
        send_word(VAL_TWO, EXP_ONES);
        send_word(VAL_ONE, EXP_W'(1) << (EXP_W - 1));
        send_word(VAL_W'(12345), EXP_W'({(EXP_W + 1) / 2{2'b01}}));
        // Bases at and just above the modulus.
        send_word(MOD_RESET, EXP_W'(3));
        send_word(MOD_RESET + VAL_ONE, EXP_W'(1));
    endtask

    // Smallest and largest legal moduli, then the degenerate ones.
    task automatic test_modulus_extremes();
        logic [VAL_W-1:0] moduli[4];
        moduli = '{VAL_TWO, BASE_MAX, VAL_ONE, '0};
        foreach (moduli[i]) begin
            set_modulus(moduli[i]);
            send_word(VAL_W'($urandom), '0);
            send_word(BASE_MAX, EXP_W'(1));
            send_word(VAL_W'($urandom), EXP_W'($urandom_range(2, 4000)));
        end
    endtask

    task automatic test_random_traffic(input logic [VAL_W-1:0] m, input int count,
                                       input bit bursty, input bit stalls);
        set_modulus(m);
        sender_bursty = bursty;
        receiver_stalls = stalls;
        repeat (count) send_word(random_base(), random_exponent());
    endtask

    // While stalls are enabled, receiver readiness follows a 32-bit pattern that is
    // reloaded once all its bits are used; some reloads stall for the whole window, some never stall.
    always @(negedge aclk) begin
        if (ready_slot == 0) begin
            case ($urandom_range(0, 3))
                0: ready_pattern = '0;
                1: ready_pattern = '1;
                default: ready_pattern = $urandom;
            endcase
            ready_slot = 32;
        end
        ready_slot--;
        m_axis_tready = !receiver_stalls || ready_pattern[ready_slot];
    end

    // Compare each accepted result word with the oldest expectation.
    always @(posedge aclk) begin
        power_job_t job;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            if (pending_powers.size() == 0) begin
                report_mismatch($sformatf("unexpected word %h", m_axis_tdata));
            end else begin
                job = pending_powers.pop_front();
                if (m_axis_tdata[VAL_W-1:0] !== job.power) begin
                    report_mismatch($sformatf("%0d ^ %h: power_result %0d, want %0d",
                                              job.base_value, job.exponent,
                                              m_axis_tdata[VAL_W-1:0], job.power));
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_CAP) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        aresetn = 1'b0;
        cfg_wen = 1'b0;
        cfg_wdata = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        modulus_copy = MOD_RESET;
        repeat (4) @(negedge aclk);
        aresetn = 1'b1;

        test_zero_exponent();
        test_field_extremes();
        test_modulus_extremes();
        test_random_traffic(MOD_RESET, 48, 1'b1, 1'b1);
        test_random_traffic(BASE_MAX, 48, 1'b0, 1'b0);
        test_random_traffic(VAL_W'($urandom_range(2, 64)), 48, 1'b1, 1'b1);
        test_random_traffic(VAL_W'($urandom) | VAL_W'(1 << 30), 48, 1'b1, 1'b0);
        test_random_traffic(VAL_W'(3), 24, 1'b0, 1'b1);
        test_random_traffic(VAL_W'($urandom_range(0, 1)), 24, 1'b1, 1'b1);
        test_random_traffic(VAL_W'($urandom_range(2, 32'h7fff_ffff)), 27, 1'b1, 1'b1);

        drain();
        repeat (SETTLE) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
